>>> sv/hcb_pkg.sv
// Shared types, constants and helpers for the Huffman code builder.
package hcb_pkg;

  localparam int SYM_W    = 8;
  localparam int ALPHA    = 256;
  localparam int CNT_W    = 24;
  localparam int CODE_W   = 48;
  localparam int LEN_W    = 6;
  localparam int NODE_AW  = 9;
  localparam int NODE_N   = 511;
  localparam int WGT_W    = 32;
  localparam int SUM_W    = 32;
  localparam int DIST_W   = 9;
  localparam int WLK_W    = 9;
  localparam int LG_W     = 4;
  localparam int OP_W     = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 160;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_COUNT  = 2'd1,
    OP_BUILD  = 2'd2,
    OP_ENCODE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_CODE   = 2'd1,
    STAT_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_EXEC,
    CMD_EMIT,
    CMD_INIT_RD,
    CMD_INIT_WR,
    CMD_PLAN,
    CMD_SCAN,
    CMD_SCAN_END,
    CMD_MRG_A,
    CMD_MRG_B,
    CMD_MRG_N,
    CMD_C_RD,
    CMD_C_CHK,
    CMD_C_WALK,
    CMD_C_STEP,
    CMD_C_MUL,
    CMD_C_ACC,
    CMD_FIN
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic multi;
    logic scan_last;
    logic merge_last;
    logic cnt_zero;
    logic at_root;
    logic sym_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [SUM_W-1:0]  original_bits;
    logic [SUM_W-1:0]  encoded_bits;
    logic [DIST_W-1:0] distinct_count;
    logic [CNT_W-1:0]  frequency;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
    status_e           status;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } code_t;

  function automatic logic [LG_W-1:0] ceil_log2(input logic [DIST_W-1:0] d);
    logic [LG_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if ((DIST_W'(1) << i) < d) r = r + LG_W'(1);
    end
    return r;
  endfunction

endpackage

>>> sv/hcb_ctrl.sv
// Sequencer for clear, count, encode and the multi-phase code build.
module hcb_ctrl import hcb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  op_e      in_op_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_EMIT, S_INIT_RD, S_INIT_WR, S_PLAN, S_SCAN, S_SCAN_END,
    S_MRG_A, S_MRG_B, S_MRG_N, S_C_RD, S_C_CHK, S_C_WALK, S_C_STEP, S_C_MUL,
    S_C_ACC, S_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_ACCEPT;
          state_d  = (in_op_i == OP_BUILD) ? S_INIT_RD : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = CMD_EXEC;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = CMD_EMIT;
          state_d  = S_IDLE;
        end
      end
      S_INIT_RD: begin
        cmd_o.op = CMD_INIT_RD;
        state_d  = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd_o.op = CMD_INIT_WR;
        state_d  = stat_i.init_last ? S_PLAN : S_INIT_RD;
      end
      S_PLAN: begin
        cmd_o.op = CMD_PLAN;
        state_d  = stat_i.multi ? S_SCAN : S_C_RD;
      end
      S_SCAN: begin
        cmd_o.op = CMD_SCAN;
        state_d  = stat_i.scan_last ? S_SCAN_END : S_SCAN;
      end
      S_SCAN_END: begin
        cmd_o.op = CMD_SCAN_END;
        state_d  = S_MRG_A;
      end
      S_MRG_A: begin
        cmd_o.op = CMD_MRG_A;
        state_d  = S_MRG_B;
      end
      S_MRG_B: begin
        cmd_o.op = CMD_MRG_B;
        state_d  = S_MRG_N;
      end
      S_MRG_N: begin
        cmd_o.op = CMD_MRG_N;
        state_d  = stat_i.merge_last ? S_C_RD : S_SCAN;
      end
      S_C_RD: begin
        cmd_o.op = CMD_C_RD;
        state_d  = S_C_CHK;
      end
      S_C_CHK: begin
        cmd_o.op = CMD_C_CHK;
        state_d  = stat_i.cnt_zero ? S_C_ACC : S_C_WALK;
      end
      S_C_WALK: begin
        cmd_o.op = CMD_C_WALK;
        state_d  = stat_i.at_root ? S_C_MUL : S_C_STEP;
      end
      S_C_STEP: begin
        cmd_o.op = CMD_C_STEP;
        state_d  = S_C_WALK;
      end
      S_C_MUL: begin
        cmd_o.op = CMD_C_MUL;
        state_d  = S_C_ACC;
      end
      S_C_ACC: begin
        cmd_o.op = CMD_C_ACC;
        state_d  = stat_i.sym_last ? S_FIN : S_C_RD;
      end
      S_FIN: begin
        cmd_o.op = CMD_FIN;
        state_d  = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/hcb_dp.sv
// Datapath: count, node, parent and code memories, merge scan and code walk.
module hcb_dp import hcb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [SYM_W-1:0] sym_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output res_t             out_data_o,
  output dp_stat_t         stat_o
);

  localparam logic [CNT_W-1:0]   CntMax    = '1;
  localparam logic [NODE_AW-1:0] NodeFirst = NODE_AW'(ALPHA);

  logic [CNT_W-1:0]   cnt_mem [ALPHA];
  logic [ALPHA-1:0]   cnt_vld_q;
  logic [CNT_W-1:0]   cnt_rd_q;
  logic               cnt_vrd_q;
  logic [SYM_W-1:0]   cnt_raddr;
  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_eff, cnt_new;

  logic [WGT_W:0]     node_mem [NODE_N];
  logic [WGT_W:0]     node_rd_q, node_wd;
  logic               node_we;
  logic [NODE_AW-1:0] node_wa;

  logic [NODE_AW:0]   par_mem [NODE_N];
  logic [NODE_AW:0]   par_rd_q, par_wd;
  logic               par_we;
  logic [NODE_AW-1:0] par_wa;

  code_t              code_mem [ALPHA];
  code_t              code_rd_q, code_wd;
  logic               code_we;
  logic [SYM_W-1:0]   code_raddr;

  op_e                op_q;
  logic [SYM_W-1:0]   sym_q, idx_q, root_leaf_q, mleft_q;
  logic [DIST_W-1:0]  distinct_q;
  logic [NODE_AW-1:0] next_q, j_q, pidx_q, best_i_q, sec_i_q, n_q, root_sel;
  logic               pvld_q, best_v_q, sec_v_q;
  logic [WGT_W-1:0]   best_w_q, sec_w_q, p_w;
  logic               p_act, take_best, take_sec, scan_upd;
  logic [WLK_W-1:0]   len_q;
  logic [CODE_W-1:0]  bits_q;
  logic [CNT_W-1:0]   cnt_hold_q, total_q;
  logic [SUM_W:0]     prod_q, prod_d;
  logic [SUM_W+1:0]   enc_sum;
  logic [SUM_W-1:0]   enc_q;
  logic               code_ready_q;
  logic               len_ok;
  logic [27:0]        orig_p;
  res_t               res_q, out_q;
  logic               out_valid_q;

  assign cnt_eff = cnt_vrd_q ? cnt_rd_q : '0;
  assign cnt_new = (cnt_eff == CntMax) ? cnt_eff : cnt_eff + CNT_W'(1);
  assign cnt_raddr = (cmd_i.op == CMD_ACCEPT) ? sym_i :
                     (cmd_i.op == CMD_INIT_RD || cmd_i.op == CMD_C_RD) ? idx_q : sym_q;
  assign code_raddr = (cmd_i.op == CMD_ACCEPT) ? sym_i : sym_q;
  assign cnt_we = (cmd_i.op == CMD_EXEC) && (op_q == OP_COUNT);

  assign p_w       = node_rd_q[WGT_W-1:0];
  assign p_act     = node_rd_q[WGT_W];
  assign scan_upd  = (cmd_i.op == CMD_SCAN) || (cmd_i.op == CMD_SCAN_END);
  assign take_best = pvld_q && p_act && (!best_v_q || (p_w < best_w_q));
  assign take_sec  = pvld_q && p_act && !take_best && (!sec_v_q || (p_w < sec_w_q));

  assign root_sel = stat_o.multi ? (next_q - NODE_AW'(1)) : {1'b0, root_leaf_q};
  assign len_ok   = (len_q <= WLK_W'(CODE_W));
  assign prod_d   = cnt_hold_q * len_q;
  assign enc_sum  = {2'b0, enc_q} + {1'b0, prod_q};
  assign orig_p   = total_q * ceil_log2(distinct_q);

  always_comb begin
    node_we = 1'b0;
    node_wa = next_q;
    node_wd = {1'b1, best_w_q + sec_w_q};
    par_we  = 1'b0;
    par_wa  = best_i_q;
    par_wd  = {1'b0, next_q};
    code_we = 1'b0;
    code_wd = '0;
    unique case (cmd_i.op)
      CMD_INIT_WR: begin
        node_we = 1'b1;
        node_wa = {1'b0, idx_q};
        node_wd = {(cnt_eff != '0), {(WGT_W - CNT_W){1'b0}}, cnt_eff};
      end
      CMD_MRG_A: begin
        node_we = 1'b1;
        node_wa = best_i_q;
        node_wd = {1'b0, best_w_q};
        par_we  = 1'b1;
      end
      CMD_MRG_B: begin
        node_we = 1'b1;
        node_wa = sec_i_q;
        node_wd = {1'b0, sec_w_q};
        par_we  = 1'b1;
        par_wa  = sec_i_q;
        par_wd  = {1'b1, next_q};
      end
      CMD_MRG_N: node_we = 1'b1;
      CMD_C_CHK: code_we = (cnt_eff == '0);
      CMD_C_MUL: begin
        code_we = 1'b1;
        if (len_ok) code_wd = '{valid: 1'b1, len: len_q[LEN_W-1:0], bits: bits_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cnt_rd_q  <= cnt_mem[cnt_raddr];
    node_rd_q <= node_mem[j_q];
    par_rd_q  <= par_mem[n_q];
    code_rd_q <= code_mem[code_raddr];
    if (cnt_we) cnt_mem[sym_q] <= cnt_new;
    if (node_we) node_mem[node_wa] <= node_wd;
    if (par_we) par_mem[par_wa] <= par_wd;
    if (code_we) code_mem[idx_q] <= code_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      cnt_vrd_q    <= 1'b0;
      total_q      <= '0;
      code_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      op_q         <= OP_CLEAR;
      sym_q        <= '0;
      idx_q        <= '0;
      root_leaf_q  <= '0;
      mleft_q      <= '0;
      distinct_q   <= '0;
      next_q       <= NodeFirst;
      j_q          <= '0;
      pidx_q       <= '0;
      pvld_q       <= 1'b0;
      best_v_q     <= 1'b0;
      sec_v_q      <= 1'b0;
      best_i_q     <= '0;
      sec_i_q      <= '0;
      best_w_q     <= '0;
      sec_w_q      <= '0;
      n_q          <= '0;
      len_q        <= '0;
      bits_q       <= '0;
      cnt_hold_q   <= '0;
      prod_q       <= '0;
      enc_q        <= '0;
      res_q        <= '0;
      out_q        <= '0;
    end else begin
      cnt_vrd_q <= cnt_vld_q[cnt_raddr];
      if (cmd_i.op == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (scan_upd) begin
        if (take_best) begin
          best_v_q <= 1'b1;
          best_w_q <= p_w;
          best_i_q <= pidx_q;
          sec_v_q  <= best_v_q;
          sec_w_q  <= best_w_q;
          sec_i_q  <= best_i_q;
        end else if (take_sec) begin
          sec_v_q <= 1'b1;
          sec_w_q <= p_w;
          sec_i_q <= pidx_q;
        end
      end
      unique case (cmd_i.op)
        CMD_ACCEPT: begin
          op_q       <= op_e'(op_i);
          sym_q      <= sym_i;
          res_q      <= '0;
          distinct_q <= '0;
          enc_q      <= '0;
          idx_q      <= '0;
        end
        CMD_EXEC: begin
          unique case (op_q)
            OP_CLEAR: begin
              cnt_vld_q    <= '0;
              total_q      <= '0;
              code_ready_q <= 1'b0;
            end
            OP_COUNT: begin
              cnt_vld_q[sym_q] <= 1'b1;
              code_ready_q     <= 1'b0;
              if (total_q != CntMax) total_q <= total_q + CNT_W'(1);
              res_q.frequency  <= cnt_new;
            end
            OP_BUILD: ;
            OP_ENCODE: begin
              if (!code_ready_q) begin
                res_q.status <= STAT_NOT_BUILT;
              end else if (!code_rd_q.valid) begin
                res_q.status    <= STAT_NO_CODE;
                res_q.frequency <= cnt_eff;
              end else begin
                res_q.code_bits   <= code_rd_q.bits;
                res_q.code_length <= code_rd_q.len;
                res_q.frequency   <= cnt_eff;
              end
            end
            default: ;
          endcase
        end
        CMD_EMIT: begin
          out_q <= res_q;
        end
        CMD_INIT_WR: begin
          if (cnt_eff != '0) begin
            distinct_q  <= distinct_q + DIST_W'(1);
            root_leaf_q <= idx_q;
          end
          idx_q <= idx_q + SYM_W'(1);
        end
        CMD_PLAN: begin
          next_q   <= NodeFirst;
          mleft_q  <= distinct_q[SYM_W-1:0] - SYM_W'(1);
          j_q      <= '0;
          pvld_q   <= 1'b0;
          best_v_q <= 1'b0;
          sec_v_q  <= 1'b0;
        end
        CMD_SCAN: begin
          j_q    <= j_q + NODE_AW'(1);
          pvld_q <= 1'b1;
          pidx_q <= j_q;
        end
        CMD_SCAN_END: pvld_q <= 1'b0;
        CMD_MRG_N: begin
          next_q   <= next_q + NODE_AW'(1);
          mleft_q  <= mleft_q - SYM_W'(1);
          j_q      <= '0;
          pvld_q   <= 1'b0;
          best_v_q <= 1'b0;
          sec_v_q  <= 1'b0;
        end
        CMD_C_CHK: begin
          cnt_hold_q <= cnt_eff;
          n_q        <= {1'b0, idx_q};
          len_q      <= '0;
          bits_q     <= '0;
          prod_q     <= '0;
        end
        CMD_C_STEP: begin
          if (len_q < WLK_W'(CODE_W)) bits_q[len_q[LEN_W-1:0]] <= par_rd_q[NODE_AW];
          len_q <= len_q + WLK_W'(1);
          n_q   <= par_rd_q[NODE_AW-1:0];
        end
        CMD_C_MUL: prod_q <= len_ok ? prod_d : '0;
        CMD_C_ACC: begin
          enc_q <= (enc_sum[SUM_W+1:SUM_W] != 2'b00) ? '1 : enc_sum[SUM_W-1:0];
          idx_q <= idx_q + SYM_W'(1);
        end
        CMD_FIN: begin
          res_q.distinct_count <= distinct_q;
          res_q.encoded_bits   <= enc_q;
          res_q.original_bits  <= {{(SUM_W - 28){1'b0}}, orig_p};
          code_ready_q         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.init_last  = (idx_q == '1);
  assign stat_o.multi      = (distinct_q > DIST_W'(1));
  assign stat_o.scan_last  = (j_q == next_q - NODE_AW'(1));
  assign stat_o.merge_last = (mleft_q == SYM_W'(1));
  assign stat_o.cnt_zero   = (cnt_eff == '0);
  assign stat_o.at_root    = (n_q == root_sel);
  assign stat_o.sym_last   = (idx_q == '1);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_merge_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_MRG_A) |-> (best_v_q && sec_v_q))
    else $error("merge without two active nodes");
  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_MRG_N) |-> (best_i_q != sec_i_q))
    else $error("merge picked one node twice");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_C_STEP) |-> (len_q < WLK_W'(ALPHA)))
    else $error("code walk exceeded tree depth");
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_EMIT) |=> out_valid_q)
    else $error("result not presented after emit");
`endif

endmodule

>>> sv/huffman_code_builder_core.sv
// Top level of the static Huffman code builder for byte symbols.
//
//  channel   dir  beat fields (tdata, low bit first)
//  s_axis    in   operation[1:0], symbol[9:2], zero pad to 16
//  m_axis    out  status, code_bits, code_length, frequency, distinct_count,
//                 encoded_bits, original_bits, zero pad to 160
//
// Clear, count and encode pass through an execute and an emit state, then the output handoff.
// Build loads the leaf nodes from the counts, merges the two lightest active nodes after a scan
// over all nodes so far, then walks each symbol to the root; the per-merge node scan dominates.
// Reset clears counts, the code-ready flag and the output register at once.
// One operation at a time; input waits while an operation runs or its result waits to be emitted.
module huffman_code_builder_core import hcb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operation, symbol
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status, code_bits, code_length, frequency, distinct_count, encoded_bits,
  // original_bits
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     out_data;

  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (op_e'(s_axis_tdata[OP_W-1:0])),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  hcb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (s_axis_tdata[OP_W-1:0]),
    .sym_i       (s_axis_tdata[OP_W+SYM_W-1:OP_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, out_data};

endmodule

>>> tb/tb_top.sv
// Testbench for huffman_code_builder_core: predicts each beat and checks the output stream.
`timescale 1ns / 100ps

module tb_top import hcb_pkg::*; ();

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // operation, symbol
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // status, code_bits, code_length, frequency, distinct_count, encoded_bits,
  // original_bits
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  huffman_code_builder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [CNT_W-1:0]  sym_cnt [ALPHA];
  logic [CNT_W-1:0]  sym_total;
  bit                table_ready;
  bit                tbl_valid [ALPHA];
  logic [LEN_W-1:0]  tbl_len [ALPHA];
  logic [CODE_W-1:0] tbl_bits [ALPHA];
  longint            nd_wgt [NODE_N];
  bit                nd_act [NODE_N];
  int                nd_parent [NODE_N];
  bit                nd_side [NODE_N];

  res_t expected_res_q[$];
  bit   failed = 1'b0;
  int   items_sent = 0;
  bit   tx_idle_en = 1'b1;
  bit   rx_idle_en = 1'b1;
  int   rx_hold = 0;

  function automatic int lightest_node(int limit);
    int best;
    best = -1;
    for (int i = 0; i < limit; i++)
      if (nd_act[i] && (best < 0 || nd_wgt[i] < nd_wgt[best])) best = i;
    return best;
  endfunction

  function automatic res_t build_huffman();
    res_t r;
    int nxt, live, root, a, b, n, len;
    longint distinct, enc, orig, lg;
    logic [63:0] bits;
    r = '0;
    distinct = 0;
    enc = 0;
    live = 0;
    for (int i = 0; i < NODE_N; i++) begin
      nd_act[i] = 0; nd_wgt[i] = 0; nd_parent[i] = -1; nd_side[i] = 0;
    end
    for (int i = 0; i < ALPHA; i++) begin
      nd_wgt[i] = sym_cnt[i];
      nd_act[i] = sym_cnt[i] != 0;
      if (nd_act[i]) begin live++; distinct++; end
    end
    nxt = ALPHA;
    while (live > 1 && nxt < NODE_N) begin
      a = lightest_node(nxt); nd_act[a] = 0;
      b = lightest_node(nxt); nd_act[b] = 0;
      nd_wgt[nxt] = nd_wgt[a] + nd_wgt[b];
      nd_act[nxt] = 1;
      nd_parent[a] = nxt; nd_side[a] = 0;
      nd_parent[b] = nxt; nd_side[b] = 1;
      nxt++;
      live--;
    end
    root = lightest_node(nxt);
    for (int s = 0; s < ALPHA; s++) begin
      tbl_valid[s] = 0; tbl_len[s] = '0; tbl_bits[s] = '0;
      if (sym_cnt[s] != 0 && root >= 0) begin
        bits = '0; len = 0; n = s;
        while (n != root && n >= 0 && len < NODE_N) begin
          if (len < 64) bits[len] = nd_side[n];
          len++;
          n = nd_parent[n];
        end
        if (len <= CODE_W) begin
          tbl_valid[s] = 1; tbl_len[s] = LEN_W'(len); tbl_bits[s] = bits[CODE_W-1:0];
          enc += longint'(sym_cnt[s]) * len;
          if (enc > 64'hFFFF_FFFF) enc = 64'hFFFF_FFFF;
        end
      end
    end
    lg = 0;
    while (lg < 16 && (64'd1 << lg) < distinct) lg++;
    orig = longint'(sym_total) * lg;
    if (orig > 64'hFFFF_FFFF) orig = 64'hFFFF_FFFF;
    table_ready = 1;
    r.distinct_count = DIST_W'(distinct);
    r.encoded_bits = SUM_W'(enc);
    r.original_bits = SUM_W'(orig);
    return r;
  endfunction

  function automatic res_t predict_result(op_e op, logic [SYM_W-1:0] sym);
    res_t r;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_CLEAR: begin
        foreach (sym_cnt[i]) sym_cnt[i] = '0;
        sym_total = '0;
        table_ready = 0;
      end
      OP_COUNT: begin
        table_ready = 0;
        if (sym_cnt[sym] != '1) sym_cnt[sym]++;
        if (sym_total != '1) sym_total++;
        r.frequency = sym_cnt[sym];
      end
      OP_BUILD: r = build_huffman();
      default: begin
        if (!table_ready) r.status = STAT_NOT_BUILT;
        else if (!tbl_valid[sym]) begin
          r.status = STAT_NO_CODE;
          r.frequency = sym_cnt[sym];
        end else begin
          r.code_bits = tbl_bits[sym];
          r.code_length = tbl_len[sym];
          r.frequency = sym_cnt[sym];
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(op_e op, logic [SYM_W-1:0] sym);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-SYM_W-OP_W){1'b0}}, sym, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_res_q.insert(expected_res_q.size(), predict_result(op, sym));
    items_sent++;
  endtask

  // output side
  initial begin
    res_t got, exp_r;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = res_t'(m_axis_tdata[RES_W-1:0]);
      if (expected_res_q.size() == 0) begin
        $error("unexpected beat %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        exp_r = expected_res_q.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); failed = 1'b1;
        end
        if (got.code_bits !== exp_r.code_bits) begin
          $error("code_bits exp %h got %h", exp_r.code_bits, got.code_bits); failed = 1'b1;
        end
        if (got.code_length !== exp_r.code_length) begin
          $error("code_length exp %0d got %0d", exp_r.code_length, got.code_length);
          failed = 1'b1;
        end
        if (got.frequency !== exp_r.frequency) begin
          $error("frequency exp %0d got %0d", exp_r.frequency, got.frequency); failed = 1'b1;
        end
        if (got.distinct_count !== exp_r.distinct_count) begin
          $error("distinct_count exp %0d got %0d", exp_r.distinct_count, got.distinct_count);
          failed = 1'b1;
        end
        if (got.encoded_bits !== exp_r.encoded_bits) begin
          $error("encoded_bits exp %0d got %0d", exp_r.encoded_bits, got.encoded_bits);
          failed = 1'b1;
        end
        if (got.original_bits !== exp_r.original_bits) begin
          $error("original_bits exp %0d got %0d", exp_r.original_bits, got.original_bits);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_ENCODE, 8'd5);      // not built yet
    send_item(OP_BUILD, 8'd0);       // empty alphabet
    send_item(OP_ENCODE, 8'd5);      // no code
    send_item(OP_COUNT, 8'hFF);
    send_item(OP_COUNT, 8'hFF);
    send_item(OP_BUILD, 8'd0);       // single symbol, zero-length code
    send_item(OP_ENCODE, 8'hFF);
    send_item(OP_COUNT, 8'h00);
    send_item(OP_ENCODE, 8'hFF);     // count dropped the table
    send_item(OP_COUNT, 8'hAA);
    send_item(OP_COUNT, 8'h55);
    send_item(OP_COUNT, 8'h55);
    send_item(OP_BUILD, 8'h3C);      // ties between equal weights
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_ENCODE, 8'hAA);
    send_item(OP_ENCODE, 8'h55);
    send_item(OP_ENCODE, 8'hFF);
    send_item(OP_ENCODE, 8'h12);
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_ENCODE, 8'h55);
    send_item(OP_BUILD, 8'd0);
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    tx_idle_en = 1'b0;
    for (int i = 0; i < 20; i++) send_item(OP_COUNT, SYM_W'($urandom_range(0, 3)));
    tx_idle_en = 1'b1;
    send_item(OP_BUILD, 8'd0);
    for (int i = 0; i < 4; i++) send_item(OP_ENCODE, SYM_W'(i));
  endtask

  task automatic test_random();
    logic [SYM_W-1:0] alpha_set[$];
    int k, n;
    while (items_sent < 480) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      alpha_set.delete();
      send_item(OP_CLEAR, SYM_W'($urandom));
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < k; i++) alpha_set.insert(alpha_set.size(), SYM_W'($urandom));
      n = $urandom_range(k, 3 * k + 4);
      for (int i = 0; i < n; i++)
        send_item(OP_COUNT, alpha_set[$urandom_range(0, $urandom_range(0, k - 1))]);
      if ($urandom_range(0, 9) == 0) send_item(OP_ENCODE, alpha_set[0]);
      send_item(OP_BUILD, SYM_W'($urandom));
      for (int i = 0; i < 6; i++)
        send_item(OP_ENCODE, ($urandom_range(0, 4) == 0) ? SYM_W'($urandom)
                                                        : alpha_set[$urandom_range(0, k - 1)]);
      if ($urandom_range(0, 4) == 0)
        for (int i = 0; i < 3; i++) send_item(op_e'($urandom_range(0, 3)), SYM_W'($urandom));
    end
  endtask

  initial begin
    foreach (sym_cnt[i]) begin
      sym_cnt[i] = '0; tbl_valid[i] = 0; tbl_len[i] = '0; tbl_bits[i] = '0;
    end
    sym_total = '0;
    table_ready = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    wait (expected_res_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
sv/hcb_pkg.sv
sv/hcb_ctrl.sv
sv/hcb_dp.sv
sv/huffman_code_builder_core.sv
tb/tb_top.sv
